// ===== rtl/swp_pkg.sv =====
// Shared types, operation codes and sizes for the swap slot table.
`default_nettype none
package swp_pkg;

    localparam int SLOTS_DEF = 1024;
    localparam int OP_W      = 3;
    localparam int IDX_W     = 10;
    localparam int PAGE_W    = 20;
    localparam int PID_W     = 6;

    localparam logic [OP_W-1:0] OP_FIND    = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOC   = 3'd1;
    localparam logic [OP_W-1:0] OP_STORE   = 3'd2;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd3;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [IDX_W-1:0]  slot_index;
        logic [PAGE_W-1:0] vpage;
        logic [PID_W-1:0]  process_id;
    } t_in;

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  result_slot;
        logic [PAGE_W-1:0] held_page;
        logic [PID_W-1:0]  held_process;
    } t_out;

    // One memory word per slot.
    typedef struct packed {
        logic              free;
        logic [PAGE_W-1:0] page;
        logic [PID_W-1:0]  pid;
    } t_entry;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RLS,
        S_FIN
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/swp_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module swp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/swap_slot_table.sv =====
// Top level of the swap slot table: request sequencer around one slot memory.
// From input transfer to result: store, unknown operation and out-of-range release pass
//   S_EXEC and S_FIN, release S_EXEC, S_RLS and S_FIN; find_free, allocate and lookup
//   scan slots from 0 up in S_SCAN, then S_FIN (one memory read per cycle, first fit).
// One item is in work at a time; the next input transfer can be taken in the cycle after
//   the result moves to the output register, even while that result is still stalled.
// Reset: synchronous, active low; then a clearing pass marks every slot free in address
//   order, with o_in_stall held high until it ends.
`default_nettype none
module swap_slot_table #(
    parameter int SLOTS = swp_pkg::SLOTS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire swp_pkg::t_in i_in,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output swp_pkg::t_out     o_out
);
    import swp_pkg::*;

    localparam int SW = $clog2(SLOTS);      // slot address width
    localparam int CW = $clog2(SLOTS + 1);  // counter that can hold SLOTS

    // Reduce a slot address to the 10-bit result field.
    function automatic logic [IDX_W-1:0] to_result_slot(input logic [SW-1:0] a);
        logic [31:0] w;
        w = 32'(a);
        return w[IDX_W-1:0];
    endfunction

    // Sequencer state
    t_state         r_state, n_state;
    logic [CW-1:0]  r_cnt, n_cnt;           // clear sweep / scan read pointer
    logic           r_rd_vld, n_rd_vld;     // memory data belongs to a read issued last cycle
    logic [SW-1:0]  r_rd_addr, n_rd_addr;   // address of that read
    t_in            r_req, n_req;           // request under work
    t_out           r_res, n_res;           // finished result waiting for the output register
    logic           r_out_vld, n_out_vld;
    t_out           r_out, n_out;

    // Memory port
    logic           ram_we;
    logic [SW-1:0]  ram_waddr;
    t_entry         ram_wdata;
    logic           ram_re;
    logic [SW-1:0]  ram_raddr;
    logic [$bits(t_entry)-1:0] ram_rdata;
    t_entry         q;

    // Decode
    logic [31:0]    idx32;
    logic           in_range;
    logic [SW-1:0]  idx_addr;
    logic           in_xfer;
    logic           is_lookup;
    logic           match;
    logic           last;
    logic           scan_more;
    logic           out_free;

    swp_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOTS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign q = t_entry'(ram_rdata);

    always_comb begin
        idx32 = 32'(r_req.slot_index);
    end

    assign in_range  = idx32 < 32'(SLOTS);
    assign idx_addr  = idx32[SW-1:0];
    assign in_xfer   = i_in_valid && !o_in_stall;
    assign is_lookup = r_req.operation == OP_LOOKUP;

    // A scan answers on the first entry that is free (find/allocate) or used with the
    // same page number (lookup); the owner id plays no part in the compare.
    assign match = r_rd_vld && (is_lookup ? (!q.free && q.page == r_req.vpage)
                                          : q.free);
    assign last      = r_rd_vld && r_rd_addr == SW'(SLOTS - 1);
    assign scan_more = r_cnt < CW'(SLOTS);
    assign out_free  = !r_out_vld || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_cnt == CW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in.operation == OP_FIND || i_in.operation == OP_ALLOC ||
                        i_in.operation == OP_LOOKUP) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (r_req.operation == OP_RELEASE && in_range) begin
                    n_state = S_RLS;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SCAN: begin
                if (match || last) begin
                    n_state = S_FIN;
                end
            end
            S_RLS: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Datapath, memory control and result capture
    always_comb begin
        n_cnt     = r_cnt;
        n_req     = r_req;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        ram_we    = 1'b0;
        ram_waddr = r_cnt[SW-1:0];
        ram_wdata = '{free: 1'b1, page: '0, pid: '0};
        ram_re    = 1'b0;
        ram_raddr = r_cnt[SW-1:0];

        // Drop the shown result once it transfers.
        if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                // Mark one slot free per cycle.
                ram_we = 1'b1;
                n_cnt  = r_cnt + CW'(1);
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_req = i_in;
                    n_cnt = '0;
                end
            end
            S_EXEC: begin
                n_res = '0;
                if (r_req.operation == OP_STORE && in_range) begin
                    ram_we      = 1'b1;
                    ram_waddr   = idx_addr;
                    ram_wdata   = '{free: 1'b0, page: r_req.vpage,
                                    pid: r_req.process_id};
                    n_res.hit   = 1'b1;
                    n_res.result_slot = to_result_slot(idx_addr);
                end else if (r_req.operation == OP_RELEASE && in_range) begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_addr;
                end
            end
            S_SCAN: begin
                // Advance the read pointer until an entry answers or the table ends.
                if (scan_more && !match) begin
                    ram_re = 1'b1;
                    n_cnt  = r_cnt + CW'(1);
                end
                n_res = '0;
                if (match) begin
                    n_res.hit         = 1'b1;
                    n_res.result_slot = to_result_slot(r_rd_addr);
                    if (is_lookup) begin
                        n_res.held_page    = q.page;
                        n_res.held_process = q.pid;
                    end else if (r_req.operation == OP_ALLOC) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_rd_addr;
                        ram_wdata = '{free: 1'b0, page: r_req.vpage,
                                      pid: r_req.process_id};
                    end
                end
            end
            S_RLS: begin
                n_res = '0;
                if (!q.free) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_rd_addr;
                    ram_wdata = '{free: 1'b1, page: q.page, pid: q.pid};
                    n_res.hit          = 1'b1;
                    n_res.result_slot  = to_result_slot(r_rd_addr);
                    n_res.held_page    = q.page;
                    n_res.held_process = q.pid;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase

        n_rd_vld  = ram_re;
        n_rd_addr = ram_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
        r_rd_addr <= n_rd_addr;
        r_req     <= n_req;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // A miss never leaks a slot or stale held data.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.hit) |->
            (o_out.result_slot == '0 && o_out.held_page == '0 && o_out.held_process == '0))
        else $error("miss result carries nonzero fields");

    // A scan hit always comes from a read issued the cycle before.
    a_scan_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && match) |-> $past(ram_re))
        else $error("scan matched on stale memory data");

    // Only allocate writes during a scan.
    a_scan_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && ram_we) |-> r_req.operation == OP_ALLOC)
        else $error("memory written during a non-allocate scan");

    // The read pointer never runs past the table.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(SLOTS))
        else $error("scan pointer past end of table");

endmodule
`default_nettype wire
